// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = $clog2(MAX_PROCS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [3:0]        slot;
    logic [15:0]       arrival;
    logic [15:0]       burst_length;
    logic [7:0]        priority_level;
  } pps_item_t;

  typedef struct packed {
    logic              idle;
    logic [3:0]        running_slot;
    logic              segment_start;
    logic [15:0]       now_time;
    logic              finished;
    logic [15:0]       complete_at;
    logic [15:0]       wait_span;
    logic [15:0]       turn_span;
    logic              all_done;
  } pps_result_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] remaining;
  } pps_entry_t;

  localparam int ENTRY_W = $bits(pps_entry_t);

endpackage

`default_nettype wire

// ===== hdl/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Process table in one RAM; each tick scans the slots in use and runs the
// most urgent ready process for one time unit.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The result of a
// load appears on the next cycle. In a tick, the slots in use (a 0 count
// acts as 1, above 16 as 16) are scanned one slot per cycle through the
// single read port of the table RAM, then the chosen entry is written back.
// Each result is shown for exactly one cycle with done high and must be taken
// then; the receiver cannot stall it.
`default_nettype none

module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire pps_item_t   item,
  output logic             done,
  output pps_result_t      result,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t                state;
  logic [4:0]            process_count;
  logic [TIME_W-1:0]     time_now;
  logic [MAX_PROCS-1:0]  nz;
  logic                  last_valid;
  logic [SLOT_W-1:0]     last_slot;
  logic [CNT_W-1:0]      idx;
  logic                  rd_v;
  logic [SLOT_W-1:0]     rd_slot;
  logic                  found;
  logic [SLOT_W-1:0]     best_slot;
  pps_entry_t            best;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  pps_entry_t            ram_wdata;
  pps_entry_t            rd_entry;

  logic [CNT_W-1:0]      n_use;
  logic [MAX_PROCS-1:0]  use_mask;
  logic                  load_go;
  logic                  tick_go;
  logic                  cand;
  logic [MAX_PROCS-1:0]  nz_load;
  logic [MAX_PROCS-1:0]  nz_tick;
  logic [TIME_W-1:0]     time_next;
  logic [TIME_W-1:0]     rem_next;
  logic [TIME_W-1:0]     turn;
  logic [TIME_W-1:0]     wait_t;
  pps_result_t           result_next;

  pps_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (rd_entry)
  );

  assign busy    = (state != ST_IDLE);
  assign load_go = (state == ST_IDLE) && start && (item.kind == KIND_LOAD);
  assign tick_go = (state == ST_IDLE) && start && (item.kind == KIND_TICK);

  always_comb begin
    if (process_count == 5'd0) begin
      n_use = CNT_W'(1);
    end else if (32'(process_count) > MAX_PROCS) begin
      n_use = CNT_W'(MAX_PROCS);
    end else begin
      n_use = CNT_W'(process_count);
    end
    for (int i = 0; i < MAX_PROCS; i++) begin
      use_mask[i] = (CNT_W'(i) < n_use);
    end
  end

  always_comb begin
    cand = rd_v && nz[rd_slot] && (rd_entry.arrival <= time_now) &&
           (!found || (rd_entry.prio < best.prio));
    time_next = (time_now == TIME_MAX) ? time_now : time_now + TIME_W'(1);
    rem_next  = best.remaining - TIME_W'(1);
    turn      = (time_next >= best.arrival) ? time_next - best.arrival : '0;
    wait_t    = (turn >= best.burst) ? turn - best.burst : '0;
    nz_load   = nz;
    nz_load[item.slot[SLOT_W-1:0]] = (item.burst_length != 16'd0);
    nz_tick   = nz;
    if (found) begin
      nz_tick[best_slot] = (rem_next != '0);
    end
  end

  always_comb begin
    result_next = '0;
    if (state == ST_FINISH) begin
      result_next.now_time = 16'(time_next);
      result_next.all_done = ~|(nz_tick & use_mask);
      if (found) begin
        result_next.running_slot  = 4'(best_slot);
        result_next.segment_start = !last_valid || (last_slot != best_slot);
        if (rem_next == '0) begin
          result_next.finished    = 1'b1;
          result_next.complete_at = 16'(time_next);
          result_next.wait_span   = 16'(wait_t);
          result_next.turn_span   = 16'(turn);
        end
      end else begin
        result_next.idle = 1'b1;
      end
    end else begin
      result_next.idle     = 1'b1;
      result_next.now_time = 16'(time_now);
      result_next.all_done = ~|(nz_load & use_mask);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item.slot[SLOT_W-1:0];
    ram_wdata.arrival   = TIME_W'(item.arrival);
    ram_wdata.burst     = TIME_W'(item.burst_length);
    ram_wdata.prio      = PRIO_W'(item.priority_level);
    ram_wdata.remaining = TIME_W'(item.burst_length);
    if (load_go) begin
      ram_we = 1'b1;
    end else if ((state == ST_FINISH) && found) begin
      ram_we    = 1'b1;
      ram_waddr = best_slot;
      ram_wdata = best;
      ram_wdata.remaining = rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      process_count <= 5'd1;
      time_now      <= '0;
      nz            <= '0;
      last_valid    <= 1'b0;
      last_slot     <= '0;
      idx           <= '0;
      rd_v          <= 1'b0;
      found         <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= load_go || (state == ST_FINISH);
      if (cfg_we) begin
        process_count <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (load_go) begin
            nz     <= nz_load;
            result <= result_next;
          end else if (tick_go) begin
            idx   <= '0;
            rd_v  <= 1'b0;
            found <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_v    <= (idx < n_use);
          rd_slot <= idx[SLOT_W-1:0];
          if (idx < n_use) begin
            idx <= idx + CNT_W'(1);
          end
          if (cand) begin
            found     <= 1'b1;
            best_slot <= rd_slot;
            best      <= rd_entry;
          end
          if ((idx == n_use) && !rd_v) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          time_now <= time_next;
          nz       <= nz_tick;
          result   <= result_next;
          if (found) begin
            last_valid <= 1'b1;
            last_slot  <= best_slot;
          end else begin
            last_valid <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pps_ram.sv =====
// ----------------------------------------------------------------------------
// pps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler testbench
// Directed and random transactions on the command port. A predictor with its
// own process table computes each expected result, and a checker compares
// every strobed result field by field against the oldest prediction.
// Covers slot count limits, reload, zero burst, preemption, idle ticks and
// entries that arrive far in the future.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import pps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1800;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pps_item_t   item;
  logic        done;
  pps_result_t result;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;

  logic [TIME_W-1:0] arr_tab [MAX_PROCS];
  logic [TIME_W-1:0] bur_tab [MAX_PROCS];
  logic [TIME_W-1:0] rem_tab [MAX_PROCS];
  logic [PRIO_W-1:0] pri_tab [MAX_PROCS];
  logic [TIME_W-1:0] clock_now;
  logic [4:0]        proc_count;
  bit                last_ok;
  int                last_slot;

  pps_result_t expected_results [$];
  pps_result_t oldest;
  int          errors;
  int          quiet_cycles;
  int          random_items;

  preemptive_priority_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int slots_active();
    if (proc_count == 0) return 1;
    if (proc_count > MAX_PROCS) return MAX_PROCS;
    return int'(proc_count);
  endfunction

  function automatic bit all_clear();
    int n;
    bit ok;
    n = slots_active();
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (rem_tab[i] != 0) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic pps_result_t schedule_item(pps_item_t it);
    pps_result_t r;
    int          n;
    int          pick;
    bit          hit;
    int unsigned turn_t;
    int unsigned wait_t;
    r = '0;
    if (it.kind == KIND_LOAD) begin
      arr_tab[it.slot] = it.arrival;
      bur_tab[it.slot] = it.burst_length;
      pri_tab[it.slot] = it.priority_level;
      rem_tab[it.slot] = it.burst_length;
      r.idle = 1'b1;
      r.now_time = clock_now;
      r.all_done = all_clear();
      return r;
    end
    n = slots_active();
    hit = 1'b0;
    pick = 0;
    for (int i = 0; i < n; i++) begin
      if (arr_tab[i] <= clock_now && rem_tab[i] != 0 &&
          (!hit || pri_tab[i] < pri_tab[pick])) begin
        pick = i;
        hit = 1'b1;
      end
    end
    if (clock_now != TIME_MAX) clock_now = clock_now + 1'b1;
    r.now_time = clock_now;
    if (!hit) begin
      r.idle = 1'b1;
      last_ok = 1'b0;
      r.all_done = all_clear();
      return r;
    end
    r.running_slot = pick[3:0];
    r.segment_start = !last_ok || last_slot != pick;
    last_ok = 1'b1;
    last_slot = pick;
    rem_tab[pick] = rem_tab[pick] - 1'b1;
    if (rem_tab[pick] == 0) begin
      turn_t = clock_now >= arr_tab[pick] ? clock_now - arr_tab[pick] : 0;
      wait_t = turn_t >= bur_tab[pick] ? turn_t - bur_tab[pick] : 0;
      r.finished = 1'b1;
      r.complete_at = clock_now;
      r.wait_span = wait_t[15:0];
      r.turn_span = turn_t[15:0];
    end
    r.all_done = all_clear();
    return r;
  endfunction

  function automatic pps_item_t make_load(int s, int arr, int bur, int prio);
    pps_item_t it;
    it.kind = KIND_LOAD;
    it.slot = s[3:0];
    it.arrival = arr[15:0];
    it.burst_length = bur[15:0];
    it.priority_level = prio[7:0];
    return it;
  endfunction

  function automatic pps_item_t make_tick();
    pps_item_t it;
    it.kind = KIND_TICK;
    it.slot = 4'($urandom);
    it.arrival = 16'($urandom);
    it.burst_length = 16'($urandom);
    it.priority_level = 8'($urandom);
    return it;
  endfunction

  function automatic int pace(bit steady);
    return steady ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic int near_arrival();
    int a;
    a = int'(clock_now) + int'($urandom_range(0, 12));
    return a > int'(TIME_MAX) ? int'(TIME_MAX) : a;
  endfunction

  function automatic int draw_burst();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return int'($urandom_range(7, 16));
      default: return int'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic int draw_prio();
    return $urandom_range(0, 1) == 0 ? int'($urandom_range(0, 3))
                                      : int'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (errors < 50) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_item(pps_item_t it, int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_results.push_back(schedule_item(it));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    proc_count = v;
  endtask

  task automatic test_table_fill();
    send_item(make_load(0, 0, 3, 128), 0);
    send_item(make_load(1, 65535, 65535, 0), 2);
    send_item(make_load(2, 1, 2, 0), 0);
    send_item(make_load(3, 0, 0, 0), 5);
    for (int s = 4; s < MAX_PROCS; s++) begin
      send_item(make_load(s, 0, 0, 255), s % 3);
    end
  endtask

  task automatic test_count_limits();
    drain();
    set_count(5'd0);
    repeat (4) send_item(make_tick(), 0);
    drain();
    set_count(5'd31);
    send_item(make_load(0, 0, 2, 128), 1);
    repeat (5) send_item(make_tick(), 0);
    drain();
    set_count(5'd16);
    send_item(make_tick(), 3);
  endtask

  task automatic test_random_schedules();
    int        active;
    int        ticks;
    bit        steady;
    pps_item_t noise;
    while (random_items < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0: set_count(5'd0);
        1: set_count(5'($urandom_range(17, 31)));
        default: set_count(5'($urandom_range(1, 16)));
      endcase
      steady = $urandom_range(0, 3) == 0;
      active = slots_active();
      if ($urandom_range(0, 5) == 0) begin
        repeat (20) begin
          noise.kind = 1'($urandom);
          noise.slot = 4'($urandom);
          noise.arrival = 16'($urandom);
          noise.burst_length = 16'($urandom);
          noise.priority_level = 8'($urandom);
          send_item(noise, pace(steady));
          random_items++;
        end
      end else begin
        for (int s = 0; s < active; s++) begin
          send_item(make_load(s, near_arrival(), draw_burst(), draw_prio()), pace(steady));
          random_items++;
        end
        ticks = 0;
        while (!all_clear() && ticks < 300) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(make_load($urandom_range(0, active - 1), near_arrival(),
                                $urandom_range(1, 4), draw_prio()), pace(steady));
          end else begin
            send_item(make_tick(), pace(steady));
            ticks++;
          end
          random_items++;
        end
        repeat ($urandom_range(0, 2)) begin
          send_item(make_tick(), pace(steady));
          random_items++;
        end
      end
    end
  endtask

  task automatic test_late_arrival();
    drain();
    set_count(5'd1);
    send_item(make_load(0, 65535, 2, 7), 0);
    repeat (3) send_item(make_tick(), 0);
    send_item(make_load(0, int'(clock_now), 3, 255), 2);
    repeat (4) send_item(make_tick(), 1);
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, now_time", result.now_time, '0);
      end else begin
        oldest = expected_results.pop_front();
        check_field("idle", result.idle, oldest.idle);
        check_field("running_slot", result.running_slot, oldest.running_slot);
        check_field("segment_start", result.segment_start, oldest.segment_start);
        check_field("now_time", result.now_time, oldest.now_time);
        check_field("finished", result.finished, oldest.finished);
        check_field("complete_at", result.complete_at, oldest.complete_at);
        check_field("wait_span", result.wait_span, oldest.wait_span);
        check_field("turn_span", result.turn_span, oldest.turn_span);
        check_field("all_done", result.all_done, oldest.all_done);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("preemptive_priority_scheduler regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    quiet_cycles = 0;
    random_items = 0;
    clock_now = '0;
    proc_count = 5'd1;
    last_ok = 1'b0;
    last_slot = 0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      arr_tab[i] = '0;
      bur_tab[i] = '0;
      pri_tab[i] = '0;
      rem_tab[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_count_limits();
    test_random_schedules();
    test_late_arrival();
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("preemptive_priority_scheduler regression: pass");
    end else begin
      $display("preemptive_priority_scheduler regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/pps_pkg.sv
hdl/pps_ram.sv
hdl/preemptive_priority_scheduler.sv
tb/testbench.sv
